@@ sv/gcsl_pkg.sv @@
// ============================================================================
// gcsl_pkg
// Shared types and constants for the glyph cache slot lookup block.
// ============================================================================
package gcsl_pkg;

   localparam int CODE_W    = 16;
   localparam int STAMP_W   = 32;
   localparam int SLOT_W    = 6;
   // widest slot index over the supported cache sizes (up to 1024 slots)
   localparam int IDX_MAX_W = 10;

   localparam logic [STAMP_W-1:0] STAMP_MAX  = 32'hffff_ffff;
   localparam logic [CODE_W-1:0]  CODE_EMPTY = '0;

   localparam logic CMD_NEW_CALL = 1'b0;
   localparam logic CMD_LOOKUP   = 1'b1;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_FINISH
   } state_type;

   // outcome of one scan over the cache
   typedef struct packed {
      logic                 hit;
      logic [IDX_MAX_W-1:0] idx;
      logic [CODE_W-1:0]    old_code;
   } scan_res_type;

endpackage

@@ sv/gcsl_if.sv @@
// ============================================================================
// gcsl_req_if / gcsl_rsp_if
// Valid/ready channels for lookup requests and lookup responses.
// ============================================================================
interface gcsl_req_if;
   import gcsl_pkg::*;
   logic              valid;
   logic              ready;
   logic              cmd;
   logic [CODE_W-1:0] char_code;

   modport source (output valid, cmd, char_code, input ready);
   modport sink   (input valid, cmd, char_code, output ready);
endinterface

interface gcsl_rsp_if;
   import gcsl_pkg::*;
   logic              valid;
   logic              ready;
   logic [SLOT_W-1:0] slot;
   logic              hit;
   logic [CODE_W-1:0] replaced_code;

   modport source (output valid, slot, hit, replaced_code, input ready);
   modport sink   (input valid, slot, hit, replaced_code, output ready);
endinterface

@@ sv/glyph_cache_slot_lookup_core.sv @@
// ============================================================================
// glyph_cache_slot_lookup_core
// Fully associative glyph cache with oldest-stamp replacement.
//
//   channel  dir  handshake      payload
//   req_ch   in   valid/ready    cmd, char_code
//   rsp_ch   out  valid/ready    slot, hit, replaced_code
//
// A lookup runs through the accept cycle, one RAM read per slot through the
// shared compare unit, a drain step for the registered read and a commit step.
// A new-call transfer completes on acceptance, or, when the counter wraps, is
// followed by a sweep of the stamp RAM to zero. After reset a clearing pass
// over both RAMs runs before the first transfer. A stalled response holds the
// commit step.
// ============================================================================
module glyph_cache_slot_lookup_core import gcsl_pkg::*; #(
   parameter int SLOTS = 64
) (
   input  logic    clock,
   input  logic    reset,
   gcsl_req_if.sink   req_ch,
   gcsl_rsp_if.source rsp_ch
);

   localparam int IW = SLOTS > 1 ? $clog2(SLOTS) : 1;
   localparam logic [IW-1:0] LAST_IDX = IW'(SLOTS - 1);

   state_type          state_ff, state_in;
   logic [IW-1:0]      addr_ff, addr_in;
   logic               clr_codes_ff, clr_codes_in;
   logic [STAMP_W-1:0] counter_ff, counter_in;
   logic [CODE_W-1:0]  key_ff, key_in;
   logic               rd_vld_ff, rd_vld_in;
   logic [IW-1:0]      rd_idx_ff, rd_idx_in;
   logic               rsp_vld_ff, rsp_vld_in;
   logic [SLOT_W-1:0]  rsp_slot_ff, rsp_slot_in;
   logic               rsp_hit_ff, rsp_hit_in;
   logic [CODE_W-1:0]  rsp_code_ff, rsp_code_in;

   logic               req_xfer;
   logic               commit;
   logic               scan_clear;
   logic               code_we, stamp_we;
   logic [IW-1:0]      wr_addr;
   logic [CODE_W-1:0]  code_wd;
   logic [STAMP_W-1:0] stamp_wd;
   logic [CODE_W-1:0]  rd_code;
   logic [STAMP_W-1:0] rd_stamp;
   scan_res_type       res;

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign req_xfer     = req_ch.valid && req_ch.ready;
   assign commit       = (state_ff == ST_FINISH) && (!rsp_vld_ff || rsp_ch.ready);

   always_comb begin
      state_in     = state_ff;
      addr_in      = addr_ff;
      clr_codes_in = clr_codes_ff;
      counter_in   = counter_ff;
      key_in       = key_ff;
      rd_vld_in    = 1'b0;
      rd_idx_in    = addr_ff;
      rsp_vld_in   = rsp_vld_ff && !rsp_ch.ready;
      rsp_slot_in  = rsp_slot_ff;
      rsp_hit_in   = rsp_hit_ff;
      rsp_code_in  = rsp_code_ff;
      scan_clear   = 1'b0;
      code_we      = 1'b0;
      stamp_we     = 1'b0;
      wr_addr      = addr_ff;
      code_wd      = CODE_EMPTY;
      stamp_wd     = '0;
      case (state_ff)
         ST_CLEAR: begin
            code_we  = clr_codes_ff;
            stamp_we = 1'b1;
            if (addr_ff == LAST_IDX) begin
               addr_in      = '0;
               clr_codes_in = 1'b0;
               state_in     = ST_IDLE;
            end else begin
               addr_in = addr_ff + 1'b1;
            end
         end
         ST_IDLE: begin
            if (req_xfer) begin
               addr_in = '0;
               if (req_ch.cmd == CMD_NEW_CALL) begin
                  counter_in = counter_ff + 1'b1;
                  // wrap to zero: sweep all stamps back to zero
                  if (counter_in == '0) begin
                     state_in = ST_CLEAR;
                  end
               end else begin
                  key_in     = req_ch.char_code;
                  scan_clear = 1'b1;
                  state_in   = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            rd_vld_in = 1'b1;
            if (addr_ff == LAST_IDX) begin
               state_in = ST_DRAIN;
            end else begin
               addr_in = addr_ff + 1'b1;
            end
         end
         ST_DRAIN: begin
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (commit) begin
               rsp_vld_in  = 1'b1;
               rsp_slot_in = res.idx[SLOT_W-1:0];
               rsp_hit_in  = res.hit;
               rsp_code_in = res.old_code;
               wr_addr     = res.idx[IW-1:0];
               code_wd     = key_ff;
               stamp_wd    = counter_ff;
               code_we     = !res.hit;
               stamp_we    = !res.hit;
               state_in    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         addr_ff      <= '0;
         clr_codes_ff <= 1'b1;
         counter_ff   <= '0;
         rd_vld_ff    <= 1'b0;
         rsp_vld_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         addr_ff      <= addr_in;
         clr_codes_ff <= clr_codes_in;
         counter_ff   <= counter_in;
         rd_vld_ff    <= rd_vld_in;
         rsp_vld_ff   <= rsp_vld_in;
      end
      key_ff      <= key_in;
      rd_idx_ff   <= rd_idx_in;
      rsp_slot_ff <= rsp_slot_in;
      rsp_hit_ff  <= rsp_hit_in;
      rsp_code_ff <= rsp_code_in;
   end

   gcsl_ram #(
      .WIDTH (CODE_W),
      .DEPTH (SLOTS)
   ) u_code_ram (
      .clock   (clock),
      .wr_en   (code_we),
      .wr_addr (wr_addr),
      .wr_data (code_wd),
      .rd_addr (addr_ff),
      .rd_data (rd_code)
   );

   gcsl_ram #(
      .WIDTH (STAMP_W),
      .DEPTH (SLOTS)
   ) u_stamp_ram (
      .clock   (clock),
      .wr_en   (stamp_we),
      .wr_addr (wr_addr),
      .wr_data (stamp_wd),
      .rd_addr (addr_ff),
      .rd_data (rd_stamp)
   );

   gcsl_scan #(
      .SLOTS (SLOTS)
   ) u_scan (
      .clock    (clock),
      .reset    (reset),
      .clear    (scan_clear),
      .rd_vld   (rd_vld_ff),
      .rd_idx   (rd_idx_ff),
      .rd_code  (rd_code),
      .rd_stamp (rd_stamp),
      .key      (key_ff),
      .res      (res)
   );

   assign rsp_ch.valid         = rsp_vld_ff;
   assign rsp_ch.slot          = rsp_slot_ff;
   assign rsp_ch.hit           = rsp_hit_ff;
   assign rsp_ch.replaced_code = rsp_code_ff;

   a_lookup_starts_scan: assert property (@(posedge clock) disable iff (reset)
      (req_xfer && req_ch.cmd == CMD_LOOKUP) |=> state_ff == ST_SCAN)
      else $error("lookup transfer did not start a scan");

   a_wrap_sweeps_stamps: assert property (@(posedge clock) disable iff (reset)
      (req_xfer && req_ch.cmd == CMD_NEW_CALL && counter_ff == STAMP_MAX)
      |=> (state_ff == ST_CLEAR && !clr_codes_ff))
      else $error("counter wrap did not sweep the stamps");

   a_rsp_from_commit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_vld_ff) |-> $past(state_ff) == ST_FINISH)
      else $error("response raised outside the commit step");

   a_hit_no_replace: assert property (@(posedge clock) disable iff (reset)
      (rsp_vld_ff && rsp_hit_ff) |-> rsp_code_ff == CODE_EMPTY)
      else $error("hit reports a replaced code");

   a_victim_in_range: assert property (@(posedge clock) disable iff (reset)
      commit |-> int'(res.idx) < SLOTS)
      else $error("selected slot beyond the cache");

endmodule

@@ sv/gcsl_ram.sv @@
// ============================================================================
// gcsl_ram
// Generic single-write, single-read RAM with registered read data.
// ============================================================================
module gcsl_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64
) (
   input  logic                                      clock,
   input  logic                                      wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                          wr_data,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                          rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ sv/gcsl_scan.sv @@
// ============================================================================
// gcsl_scan
// Compare unit stepped once per slot: tracks first match, first empty slot
// and first strictly smallest stamp, then picks the hit or the victim.
// ============================================================================
module gcsl_scan import gcsl_pkg::*; #(
   parameter int SLOTS = 64
) (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      clear,
   input  logic                                      rd_vld,
   input  logic [(SLOTS > 1 ? $clog2(SLOTS) : 1)-1:0] rd_idx,
   input  logic [CODE_W-1:0]                         rd_code,
   input  logic [STAMP_W-1:0]                        rd_stamp,
   input  logic [CODE_W-1:0]                         key,
   output scan_res_type                              res
);

   localparam int IW = SLOTS > 1 ? $clog2(SLOTS) : 1;

   logic               match_vld_ff, match_vld_in;
   logic [IW-1:0]      match_idx_ff, match_idx_in;
   logic               empty_vld_ff, empty_vld_in;
   logic [IW-1:0]      empty_idx_ff, empty_idx_in;
   logic               min_vld_ff, min_vld_in;
   logic [IW-1:0]      min_idx_ff, min_idx_in;
   logic [STAMP_W-1:0] min_stamp_ff, min_stamp_in;
   logic [CODE_W-1:0]  min_code_ff, min_code_in;
   logic [CODE_W-1:0]  code0_ff, code0_in;

   always_comb begin
      match_vld_in = match_vld_ff;
      match_idx_in = match_idx_ff;
      empty_vld_in = empty_vld_ff;
      empty_idx_in = empty_idx_ff;
      min_vld_in   = min_vld_ff;
      min_idx_in   = min_idx_ff;
      min_stamp_in = min_stamp_ff;
      min_code_in  = min_code_ff;
      code0_in     = code0_ff;
      if (clear) begin
         match_vld_in = 1'b0;
         empty_vld_in = 1'b0;
         min_vld_in   = 1'b0;
         min_stamp_in = STAMP_MAX;
      end else if (rd_vld) begin
         if (rd_code == key && !match_vld_ff) begin
            match_vld_in = 1'b1;
            match_idx_in = rd_idx;
         end
         if (rd_code == CODE_EMPTY && !empty_vld_ff) begin
            empty_vld_in = 1'b1;
            empty_idx_in = rd_idx;
         end
         // strict compare keeps the lowest slot among equal stamps
         if (rd_stamp < min_stamp_ff) begin
            min_vld_in   = 1'b1;
            min_idx_in   = rd_idx;
            min_stamp_in = rd_stamp;
            min_code_in  = rd_code;
         end
         if (rd_idx == '0) begin
            code0_in = rd_code;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         match_vld_ff <= 1'b0;
         empty_vld_ff <= 1'b0;
         min_vld_ff   <= 1'b0;
      end else begin
         match_vld_ff <= match_vld_in;
         empty_vld_ff <= empty_vld_in;
         min_vld_ff   <= min_vld_in;
      end
      match_idx_ff <= match_idx_in;
      empty_idx_ff <= empty_idx_in;
      min_idx_ff   <= min_idx_in;
      min_stamp_ff <= min_stamp_in;
      min_code_ff  <= min_code_in;
      code0_ff     <= code0_in;
   end

   always_comb begin
      res.hit      = 1'b0;
      res.idx      = '0;
      res.old_code = '0;
      if (match_vld_ff) begin
         res.hit = 1'b1;
         res.idx = IDX_MAX_W'(match_idx_ff);
      end else if (empty_vld_ff) begin
         res.idx = IDX_MAX_W'(empty_idx_ff);
      end else if (min_vld_ff) begin
         res.idx      = IDX_MAX_W'(min_idx_ff);
         res.old_code = min_code_ff;
      end else begin
         // every stamp saturated: fall back to slot 0
         res.old_code = code0_ff;
      end
   end

endmodule

@@ tb/tb.sv @@
// ============================================================================
// tb
// Testbench for glyph_cache_slot_lookup_core. A cycle-free model of the cache
// (codes, stamps, call counter) predicts every lookup response. Responses are
// checked field by field in arrival order. Traffic is a short directed set,
// then a fill-and-evict sweep, then random draw-call traffic over a code pool
// a bit larger than the cache. Both channels idle in random bursts.
// ============================================================================
module tb;
   import gcsl_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int SLOTS      = 64;
   localparam int POOL_SIZE  = 96;
   localparam int RAND_ITEMS = 1200;
   localparam int QUIET_TAIL = 150;

   typedef struct {
      logic [SLOT_W-1:0] slot;
      logic              hit;
      logic [CODE_W-1:0] replaced_code;
   } lookup_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   gcsl_req_if req_ch ();
   gcsl_rsp_if rsp_ch ();

   glyph_cache_slot_lookup_core #(.SLOTS(SLOTS)) u_top (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   always #5 clock = ~clock;

   // cache model
   logic [CODE_W-1:0]  cache_codes [SLOTS];
   logic [STAMP_W-1:0] cache_stamps[SLOTS];
   logic [STAMP_W-1:0] draw_calls;

   lookup_result_type pending_results[$];
   lookup_result_type got_res;
   lookup_result_type want_res;

   logic [CODE_W-1:0] code_pool[POOL_SIZE];

   int  errors      = 0;
   int  n_new_calls = 0;
   int  n_hits      = 0;
   int  n_misses    = 0;
   int  n_checked   = 0;
   bit  idle_en     = 1'b1;
   int  stall_left  = 0;

   initial begin
      req_ch.valid     = 1'b0;
      req_ch.cmd       = CMD_NEW_CALL;
      req_ch.char_code = '0;
      rsp_ch.ready     = 1'b0;
      foreach (cache_codes[i]) begin
         cache_codes[i]  = CODE_EMPTY;
         cache_stamps[i] = '0;
      end
      draw_calls = '0;
   end

   function automatic bit code_cached(input logic [CODE_W-1:0] code);
      foreach (cache_codes[i])
         if (cache_codes[i] == code) return 1'b1;
      return 1'b0;
   endfunction

   function automatic bit cache_has_empty();
      return code_cached(CODE_EMPTY);
   endfunction

   // first empty slot, else first slot with the smallest unsaturated stamp
   function automatic int pick_victim();
      int best;
      logic [STAMP_W-1:0] least;
      best  = 0;
      least = STAMP_MAX;
      for (int i = 0; i < SLOTS; i++) begin
         if (cache_codes[i] == CODE_EMPTY) return i;
         if (cache_stamps[i] < least) begin
            least = cache_stamps[i];
            best  = i;
         end
      end
      return best;
   endfunction

   // apply one accepted request to the model
   task automatic update_cache(input logic cmd_bit, input logic [CODE_W-1:0] code);
      int pos;
      bit found;
      lookup_result_type res;
      pos   = 0;
      found = 1'b0;
      if (cmd_bit == CMD_NEW_CALL) begin
         n_new_calls++;
         draw_calls = draw_calls + 1'b1;
         if (draw_calls == '0)
            foreach (cache_stamps[i]) cache_stamps[i] = '0;
         return;
      end
      for (int i = 0; i < SLOTS; i++) begin
         if (cache_codes[i] == code) begin
            pos   = i;
            found = 1'b1;
            break;
         end
      end
      res.replaced_code = CODE_EMPTY;
      if (!found) begin
         pos               = pick_victim();
         res.replaced_code = cache_codes[pos];
         cache_codes[pos]  = code;
         cache_stamps[pos] = draw_calls;
         n_misses++;
      end else begin
         n_hits++;
      end
      res.slot = pos[SLOT_W-1:0];
      res.hit  = found;
      pending_results.push_back(res);
   endtask

   // one request transfer; valid stays high across back-to-back transfers
   task automatic send_item(input logic cmd_bit, input logic [CODE_W-1:0] code);
      int gap;
      if (idle_en && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 16);
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid     <= 1'b1;
      req_ch.cmd       <= cmd_bit;
      req_ch.char_code <= code;
      do @(posedge clock); while (!req_ch.ready);
      update_cache(cmd_bit, code);
   endtask

   task automatic lookup(input logic [CODE_W-1:0] code);
      send_item(CMD_LOOKUP, code);
   endtask

   task automatic new_call();
      send_item(CMD_NEW_CALL, CODE_W'($urandom));
   endtask

   // response checker and ready stalls
   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         got_res.slot          = rsp_ch.slot;
         got_res.hit           = rsp_ch.hit;
         got_res.replaced_code = rsp_ch.replaced_code;
         if (pending_results.size() == 0) begin
            $error("unexpected response: slot %0d hit %0b replaced_code 0x%04h",
                   got_res.slot, got_res.hit, got_res.replaced_code);
            errors++;
         end else begin
            want_res = pending_results.pop_front();
            n_checked++;
            if (got_res.slot !== want_res.slot) begin
               $error("slot: expected %0d, actual %0d", want_res.slot, got_res.slot);
               errors++;
            end
            if (got_res.hit !== want_res.hit) begin
               $error("hit: expected %0b, actual %0b", want_res.hit, got_res.hit);
               errors++;
            end
            if (got_res.replaced_code !== want_res.replaced_code) begin
               $error("replaced_code: expected 0x%04h, actual 0x%04h",
                      want_res.replaced_code, got_res.replaced_code);
               errors++;
            end
         end
      end
      if (stall_left > 0) begin
         stall_left--;
         rsp_ch.ready <= 1'b0;
      end else if (idle_en && $urandom_range(0, 5) == 0) begin
         stall_left   = $urandom_range(1, 16) - 1;
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= 1'b1;
      end
   end

   // empty cache: code zero hits the first empty slot, field extremes
   task automatic test_basic_lookups();
      lookup(16'h0000);
      lookup(16'hffff);
      lookup(16'hffff);
      lookup(16'h0000);
      lookup(16'h0001);
      lookup(16'h8000);
      lookup(16'h5555);
      lookup(16'haaaa);
      lookup(16'h7fff);
      lookup(16'h0001);
      lookup(16'h0000);
   endtask

   // new calls change the stamp given to later fills; code is don't-care
   task automatic test_new_call_stamps();
      send_item(CMD_NEW_CALL, 16'hffff);
      lookup(16'h1234);
      send_item(CMD_NEW_CALL, 16'h0000);
      new_call();
      lookup(16'hfffe);
      lookup(16'h5555);
      lookup(16'h1234);
      new_call();
      lookup(16'h00ff);
   endtask

   // fill every slot, then force oldest-stamp evictions, incl. code zero on
   // a full cache (miss that empties the victim again)
   task automatic test_fill_and_evict();
      logic [CODE_W-1:0] code;
      while (cache_has_empty()) begin
         do code = CODE_W'($urandom_range(1, 65535)); while (code_cached(code));
         lookup(code);
         if ($urandom_range(0, 3) == 0) new_call();
      end
      lookup(16'h0000);
      lookup(16'h0000);
      lookup(16'h0000);
      for (int i = 0; i < 40; i++) begin
         do code = CODE_W'($urandom_range(1, 65535)); while (code_cached(code));
         lookup(code);
         if ($urandom_range(0, 2) == 0) new_call();
      end
   endtask

   // draw-call traffic over a pool slightly larger than the cache
   task automatic test_random_traffic();
      int pick;
      foreach (code_pool[i]) code_pool[i] = CODE_W'($urandom_range(1, 65535));
      for (int n = 0; n < RAND_ITEMS; n++) begin
         if (n == RAND_ITEMS - QUIET_TAIL) idle_en = 1'b0;
         pick = $urandom_range(0, 99);
         if (pick < 20)      new_call();
         else if (pick < 85) lookup(code_pool[$urandom_range(0, POOL_SIZE - 1)]);
         else if (pick < 95) lookup(CODE_W'($urandom));
         else                lookup(CODE_EMPTY);
      end
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      test_basic_lookups();
      test_new_call_stamps();
      test_fill_and_evict();
      test_random_traffic();

      req_ch.valid <= 1'b0;
      wait (pending_results.size() == 0);
      repeat (SLOTS + 8) @(posedge clock);

      $display("Run covered %0d new-call and %0d lookup transfers: %0d hits, %0d misses.",
               n_new_calls, n_hits + n_misses, n_hits, n_misses);
      $display("Responses checked: %0d, field mismatches: %0d.", n_checked, errors);
      if (errors == 0 && pending_results.size() == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

   initial begin
      #10_000_000;
      $display("Timeout: %0d responses still outstanding", pending_results.size());
      $display("Simulation FAILED");
      $finish;
   end

endmodule
